@@ src/wmdf_pkg.sv @@
package wmdf_pkg;

    localparam int CHAR_BINS           = 64;
    localparam int BIN_W               = 6;
    localparam int FIRST_CODE          = 63;
    localparam int LAST_CODE           = FIRST_CODE + CHAR_BINS - 1;
    localparam int MAX_WORDS_DEF       = 64;
    localparam int MAX_WORD_LENGTH_DEF = 255;
    localparam int QUEUE_DEPTH         = 4;
    localparam int QPTR_W              = 2;

    // classified character as handed from front to back
    typedef struct packed {
        logic             counted;
        logic [BIN_W-1:0] bin;
        logic             wend;
        logic             send;
    } wmdf_item_t;

endpackage

@@ src/wmdf_front.sv @@
module wmdf_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_code,
    input  logic                in_wend,
    input  logic                in_send,
    output logic                q_valid,
    output wmdf_pkg::wmdf_item_t q_item,
    input  logic                q_pop
);

    wmdf_pkg::wmdf_item_t           slot_reg [wmdf_pkg::QUEUE_DEPTH];
    logic [wmdf_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [wmdf_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [wmdf_pkg::QPTR_W:0]      fill_reg, fill_next;
    wmdf_pkg::wmdf_item_t           cls;
    logic                           push;
    logic                           pop;

    // map code to bin; codes outside the window touch no bin
    always_comb
    begin
        cls.counted = (in_code >= 8'(wmdf_pkg::FIRST_CODE))
                   && (in_code <= 8'(wmdf_pkg::LAST_CODE));
        cls.bin     = wmdf_pkg::BIN_W'(in_code - 8'(wmdf_pkg::FIRST_CODE));
        cls.wend    = in_wend;
        cls.send    = in_send;
    end

    assign in_ready = (fill_reg != (wmdf_pkg::QPTR_W+1)'(wmdf_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ src/wmdf_back.sv @@
module wmdf_back
#(
    parameter int MAX_WORDS       = wmdf_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_LENGTH = wmdf_pkg::MAX_WORD_LENGTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  wmdf_pkg::wmdf_item_t q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           out_flags,
    output logic                 out_ovf
);

    localparam int RW = $clog2(MAX_WORDS);
    localparam int CW = $clog2(MAX_WORDS + 1);
    localparam int HW = $clog2(MAX_WORD_LENGTH + 1);
    localparam int BW = wmdf_pkg::BIN_W;
    localparam int NB = wmdf_pkg::CHAR_BINS;
    localparam int AW = RW + BW;

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_ANA  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    logic [HW-1:0] hist_mem [MAX_WORDS * NB];
    logic [NB-1:0] mask_mem [MAX_WORDS];

    state_t               state_reg, state_next;
    logic                 s2_valid_reg;
    wmdf_pkg::wmdf_item_t s2_item_reg;
    logic [RW-1:0]        s2_row_reg;
    logic                 s2_live_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [NB-1:0]        binv_reg, binv_next;
    logic                 lw_valid_reg;
    logic [AW-1:0]        lw_addr_reg;
    logic [HW-1:0]        lw_data_reg;
    logic [HW-1:0]        rd_a_reg, rd_b_reg;
    logic [NB-1:0]        mk_a_reg, mk_b_reg;
    logic [CW-1:0]        n_reg, n_next;
    logic                 set_ovf_reg, set_ovf_next;
    logic [RW-1:0]        i_reg, i_next, j_reg, j_next;
    logic [BW-1:0]        b_reg, b_next;
    logic                 iss_reg, iss_next;
    logic                 d_valid_reg;
    logic [BW-1:0]        d_b_reg;
    logic                 d_blast_reg, d_jlast_reg, d_done_reg;
    logic                 acc_ij_reg, acc_ij_next, acc_ji_reg, acc_ji_next;
    logic [3:0]           wf_reg, wf_next, res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    logic [3:0]           out_flags_reg;
    logic                 out_ovf_reg;

    logic                 s2_act, counted, wend_any, do_write, do_mask;
    logic [AW-1:0]        s2_addr, rd_a_addr, rd_b_addr;
    logic [HW-1:0]        old_val, new_val;
    logic [CW-1:0]        count_aw;
    logic                 ovf_aw;
    logic [NB-1:0]        binv_upd;
    logic                 pop;
    logic [RW:0]          n_ext, jn, j_ext, i_ext;
    logic                 last_b, last_j, last_i;
    logic [HW-1:0]        va, vb;
    logic                 cur_ij, cur_ji;
    logic [3:0]           wf_upd;
    logic                 load_out;

    // ---- histogram update of the current word ----
    assign s2_act   = s2_valid_reg && (state_reg == ST_RUN);
    assign counted  = s2_item_reg.counted && s2_live_reg;
    assign wend_any = s2_item_reg.wend || s2_item_reg.send;
    assign s2_addr  = {s2_row_reg, s2_item_reg.bin};
    assign do_write = s2_act && counted;
    assign do_mask  = s2_act && wend_any && (count_reg < CW'(MAX_WORDS));

    always_comb
    begin
        old_val = '0;
        if (binv_reg[s2_item_reg.bin])
        begin
            old_val = (lw_valid_reg && (lw_addr_reg == s2_addr)) ? lw_data_reg : rd_a_reg;
        end
        new_val = (old_val < HW'(MAX_WORD_LENGTH)) ? old_val + 1'b1 : old_val;
        binv_upd = binv_reg;
        if (counted)
        begin
            binv_upd[s2_item_reg.bin] = 1'b1;
        end
        count_aw = count_reg;
        ovf_aw   = ovf_reg;
        if (s2_act && wend_any)
        begin
            if (count_reg < CW'(MAX_WORDS))
            begin
                count_aw = count_reg + 1'b1;
            end
            else
            begin
                ovf_aw = 1'b1;
            end
        end
    end

    assign pop       = (state_reg == ST_RUN) && q_valid
                    && !(s2_valid_reg && s2_item_reg.send);
    assign q_pop     = pop;
    assign rd_a_addr = (state_reg == ST_RUN) ? {count_aw[RW-1:0], q_item.bin} : {i_reg, b_reg};
    assign rd_b_addr = {j_reg, b_reg};

    // ---- pair sweep sequencer ----
    always_comb
    begin
        n_ext  = (RW+1)'(n_reg);
        i_ext  = (RW+1)'(i_reg);
        j_ext  = (RW+1)'(j_reg);
        last_b = (b_reg == BW'(NB - 1));
        jn     = j_ext + 1'b1;
        if (jn == i_ext)
        begin
            jn = j_ext + (RW+1)'(2);
        end
        last_j = (jn >= n_ext);
        last_i = ((i_ext + 1'b1) == n_ext);
    end

    // ---- compare stage ----
    always_comb
    begin
        va     = mk_a_reg[d_b_reg] ? rd_a_reg : '0;
        vb     = mk_b_reg[d_b_reg] ? rd_b_reg : '0;
        cur_ij = ((d_b_reg == '0) ? 1'b1 : acc_ij_reg) && (va >= vb);
        cur_ji = ((d_b_reg == '0) ? 1'b1 : acc_ji_reg) && (vb >= va);
        wf_upd = wf_reg & {~cur_ij, ~cur_ji, cur_ji, cur_ij};
    end

    assign load_out = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_aw;
        ovf_next       = ovf_aw;
        binv_next      = (s2_act && wend_any) ? '0 : (s2_act ? binv_upd : binv_reg);
        n_next         = n_reg;
        set_ovf_next   = set_ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        b_next         = b_reg;
        iss_next       = iss_reg;
        acc_ij_next    = acc_ij_reg;
        acc_ji_next    = acc_ji_reg;
        wf_next        = wf_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;

        unique case (state_reg)
            ST_RUN:
            begin
                if (s2_act && s2_item_reg.send)
                begin
                    n_next       = count_aw;
                    set_ovf_next = ovf_aw;
                    count_next   = '0;
                    ovf_next     = 1'b0;
                    i_next       = '0;
                    j_next       = RW'(1);
                    b_next       = '0;
                    wf_next      = 4'hF;
                    if (count_aw == CW'(1))
                    begin
                        res_next   = 4'hF;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        res_next   = '0;
                        iss_next   = 1'b1;
                        state_next = ST_ANA;
                    end
                end
            end
            ST_ANA:
            begin
                if (iss_reg)
                begin
                    b_next = b_reg + 1'b1;
                    if (last_b)
                    begin
                        if (last_j)
                        begin
                            i_next = i_reg + 1'b1;
                            j_next = '0;
                            if (last_i)
                            begin
                                iss_next = 1'b0;
                            end
                        end
                        else
                        begin
                            j_next = jn[RW-1:0];
                        end
                    end
                end
                if (d_valid_reg)
                begin
                    acc_ij_next = cur_ij;
                    acc_ji_next = cur_ji;
                    if (d_blast_reg)
                    begin
                        if (d_jlast_reg)
                        begin
                            res_next = res_reg | wf_upd;
                            wf_next  = 4'hF;
                        end
                        else
                        begin
                            wf_next = wf_upd;
                        end
                        if (d_done_reg)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            s2_valid_reg  <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            binv_reg      <= '0;
            lw_valid_reg  <= 1'b0;
            iss_reg       <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s2_valid_reg  <= pop;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            binv_reg      <= binv_next;
            lw_valid_reg  <= do_write;
            iss_reg       <= iss_next;
            d_valid_reg   <= (state_reg == ST_ANA) && iss_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s2_item_reg <= q_item;
            s2_row_reg  <= count_aw[RW-1:0];
            s2_live_reg <= (count_aw < CW'(MAX_WORDS));
        end
        lw_addr_reg   <= s2_addr;
        lw_data_reg   <= new_val;
        n_reg         <= n_next;
        set_ovf_reg   <= set_ovf_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        b_reg         <= b_next;
        d_b_reg       <= b_reg;
        d_blast_reg   <= last_b;
        d_jlast_reg   <= last_b && last_j;
        d_done_reg    <= last_b && last_j && last_i;
        acc_ij_reg    <= acc_ij_next;
        acc_ji_reg    <= acc_ji_next;
        wf_reg        <= wf_next;
        res_reg       <= res_next;
        if (load_out)
        begin
            out_flags_reg <= res_reg;
            out_ovf_reg   <= set_ovf_reg;
        end
    end

    // histogram and touched-bin memories
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            hist_mem[s2_addr] <= new_val;
        end
        rd_a_reg <= hist_mem[rd_a_addr];
        rd_b_reg <= hist_mem[rd_b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (do_mask)
        begin
            mask_mem[s2_row_reg] <= binv_upd;
        end
        mk_a_reg <= mask_mem[i_reg];
        mk_b_reg <= mask_mem[j_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_flags = out_flags_reg;
    assign out_ovf   = out_ovf_reg;

endmodule

@@ src/word_multiset_dominance_flags_top.sv @@
// Characters stream at one per cycle, held while the back end sweeps or emits, through
// a 4-entry queue and the s2 register into the histogram. At set end the pair sweep
// visits every ordered pair of the n kept words (one bin pair per cycle over the
// histogram memory's two read ports), then the result sits in the output register.
// Reset (rst_n low, asynchronous) empties the queue, clears word count, overflow flag,
// bin-touched bits and the output valid; memories need no clearing pass.
module word_multiset_dominance_flags_top
#(
    parameter int MAX_WORDS       = wmdf_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_LENGTH = wmdf_pkg::MAX_WORD_LENGTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tuser,   // [0] word_end
    input  logic       s_tlast,   // set_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [3:0] answer_flags, [4] word_overflow, [7:5] zero
);

    // front: classifies each character transaction into a bin and queues it
    // back:  counts bins per word in memory, then sweeps all ordered word pairs
    wmdf_pkg::wmdf_item_t q_item;
    logic                 q_valid;
    logic                 q_pop;
    logic [3:0]           flags;
    logic                 ovf;

    wmdf_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_code  (s_tdata),
        .in_wend  (s_tuser),
        .in_send  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    wmdf_back
    #(
        .MAX_WORDS       (MAX_WORDS),
        .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_flags (flags),
        .out_ovf   (ovf)
    );

    assign m_tdata = {3'b000, ovf, flags};

endmodule

@@ test/word_multiset_dominance_flags_top_tb.sv @@
`timescale 1ns / 1ps

module word_multiset_dominance_flags_top_tb;

    localparam int NWORDS  = wmdf_pkg::MAX_WORDS_DEF;
    localparam int SATMAX  = wmdf_pkg::MAX_WORD_LENGTH_DEF;
    localparam int NBINS   = wmdf_pkg::CHAR_BINS;
    localparam int FCODE   = wmdf_pkg::FIRST_CODE;
    localparam int LCODE   = wmdf_pkg::LAST_CODE;
    localparam int NRANDOM = 120;

    typedef struct packed {
        logic [7:0] code;
        logic       wend;
        logic       send;
    } char_txn_t;

    typedef struct packed {
        logic [3:0] flags;
        logic       ovf;
    } verdict_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    // stimulus waiting for the driver, and verdicts waiting for the block
    char_txn_t char_queue[$];
    verdict_t  verdict_queue[$];

    // predictor state
    int unsigned hist[NWORDS][NBINS];
    int unsigned words_kept;
    bit          dropped;

    int  mismatches;
    bit  calm;       // no idling on either side near the end
    bit  hold_send;  // sender pause until all verdicts are back
    int  s_gap;
    int  m_gap;

    word_multiset_dominance_flags_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // word a holds every bin of word b at least as often
    function automatic bit holds_all(int a, int b);
        for (int k = 0; k < NBINS; k++)
            if (hist[a][k] < hist[b][k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [3:0] dominance_flags(int n);
        logic [3:0] f;
        bit fa, fda, fdn, fn, ab, ba;
        f = '0;
        for (int i = 0; i < n; i++)
        begin
            fa = 1; fda = 1; fdn = 1; fn = 1;
            for (int j = 0; j < n; j++)
            begin
                if (i == j)
                    continue;
                ab = holds_all(i, j);
                ba = holds_all(j, i);
                if (ab) fn  = 0; else fa  = 0;
                if (ba) fdn = 0; else fda = 0;
            end
            if (fa)  f[0] = 1'b1;
            if (fda) f[1] = 1'b1;
            if (fdn) f[2] = 1'b1;
            if (fn)  f[3] = 1'b1;
        end
        return f;
    endfunction

    // called once per accepted character
    task automatic predict_char(char_txn_t c);
        verdict_t v;
        int bin;
        if (words_kept < NWORDS && c.code >= FCODE && c.code <= LCODE)
        begin
            bin = c.code - FCODE;
            if (hist[words_kept][bin] < SATMAX)
                hist[words_kept][bin]++;
        end
        if (c.wend || c.send)
        begin
            if (words_kept < NWORDS)
            begin
                words_kept++;
                if (words_kept < NWORDS)
                    for (int k = 0; k < NBINS; k++)
                        hist[words_kept][k] = 0;
            end
            else
                dropped = 1'b1;
        end
        if (c.send)
        begin
            v.flags = dominance_flags(words_kept);
            v.ovf   = dropped;
            verdict_queue.push_back(v);
            words_kept = 0;
            dropped    = 1'b0;
            for (int k = 0; k < NBINS; k++)
                hist[0][k] = 0;
        end
    endtask

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'($urandom_range(0, 255));
        if (r == 1)
            return 8'($urandom_range(0, 62));
        if (r == 2)
            return 8'($urandom_range(127, 255));
        // a narrow alphabet keeps dominance relations frequent
        return 8'($urandom_range(FCODE, FCODE + 4));
    endfunction

    task automatic push_word(int len, bit last_in_set, bit use_wend);
        char_txn_t c;
        for (int i = 0; i < len; i++)
        begin
            c.code = pick_code();
            c.wend = (i == len - 1) ? use_wend : 1'b0;
            c.send = (i == len - 1) ? last_in_set : 1'b0;
            char_queue.push_back(c);
        end
    endtask

    task automatic push_set(int nw, int maxlen);
        for (int w = 0; w < nw; w++)
            push_word($urandom_range(1, maxlen), w == nw - 1,
                      (w == nw - 1) ? 1'($urandom_range(0, 1)) : 1'b1);
    endtask

    // driver: a transaction is taken when s_tvalid and s_tready are high
    always @(posedge clk or negedge rst_n)
    begin
        char_txn_t c;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
            s_gap    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_char({s_tdata, s_tuser, s_tlast});
                void'(char_queue.pop_front());
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (s_gap > 0)
                begin
                    s_gap    <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 11) == 0)
                begin
                    s_gap    <= $urandom_range(0, 7);
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    // head of the queue after the pop above
                    if (char_queue.size() > 0 && !hold_send)
                    begin
                        c = char_queue[0];
                        s_tvalid <= 1'b1;
                        {s_tdata, s_tuser, s_tlast} <= c;
                    end
                    else
                        s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t exp_v;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            m_gap    <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdict_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", m_tdata);
                end
                else
                begin
                    exp_v = verdict_queue.pop_front();
                    if (m_tdata[3:0] !== exp_v.flags || m_tdata[4] !== exp_v.ovf
                        || m_tdata[7:5] !== 3'b000)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: flags exp %b got %b, ovf exp %b got %b",
                                     exp_v.flags, m_tdata[3:0], exp_v.ovf, m_tdata[4]);
                    end
                end
            end
            if (m_gap > 0)
            begin
                m_gap    <= m_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_gap    <= $urandom_range(0, 7);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        char_txn_t c;
        mismatches = 0;
        calm       = 0;
        hold_send  = 0;
        words_kept = 0;
        dropped    = 0;
        foreach (hist[i, k])
            hist[i][k] = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: single word, uncounted codes, extremes of the code field
        c = '{8'd63, 1'b0, 1'b1};            char_queue.push_back(c);
        c = '{8'd0, 1'b0, 1'b0};             char_queue.push_back(c);
        c = '{8'd255, 1'b1, 1'b0};           char_queue.push_back(c);
        c = '{8'd126, 1'b1, 1'b0};           char_queue.push_back(c);
        c = '{8'd62, 1'b0, 1'b0};            char_queue.push_back(c);
        c = '{8'd127, 1'b1, 1'b1};           char_queue.push_back(c);
        // identical words, then a strict superset
        c = '{8'd65, 1'b1, 1'b0};            char_queue.push_back(c);
        c = '{8'd65, 1'b1, 1'b0};            char_queue.push_back(c);
        c = '{8'd65, 1'b0, 1'b0};            char_queue.push_back(c);
        c = '{8'd66, 1'b0, 1'b1};            char_queue.push_back(c);
        // incomparable pair
        c = '{8'd100, 1'b1, 1'b0};           char_queue.push_back(c);
        c = '{8'd101, 1'b1, 1'b1};           char_queue.push_back(c);
        // empty-bin words (only uncounted codes)
        c = '{8'd32, 1'b1, 1'b0};            char_queue.push_back(c);
        c = '{8'd200, 1'b1, 1'b1};           char_queue.push_back(c);

        // bin saturation: 256 copies of one code against 255 copies
        for (int i = 0; i < 256; i++)
        begin
            c = '{8'd70, i == 255, 1'b0};
            char_queue.push_back(c);
        end
        for (int i = 0; i < 255; i++)
        begin
            c = '{8'd70, 1'b0, i == 254};
            char_queue.push_back(c);
        end

        // too many words: kept words plus a few dropped
        for (int w = 0; w < NWORDS + 3; w++)
        begin
            c = '{8'(FCODE + (w % 3)), 1'b1, w == NWORDS + 2};
            char_queue.push_back(c);
        end
        // exactly the capacity
        for (int w = 0; w < NWORDS; w++)
        begin
            c = '{8'(FCODE + (w % 2)), 1'b1, w == NWORDS - 1};
            char_queue.push_back(c);
        end

        wait (char_queue.size() == 0);
        // pause the sender until every verdict is back
        hold_send = 1;
        wait (verdict_queue.size() == 0);
        hold_send = 0;

        // random sets, mostly small; a few noise items with stray marks
        while (char_queue.size() < NRANDOM)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                c.code = 8'($urandom_range(0, 255));
                c.wend = 1'($urandom_range(0, 1));
                c.send = 1'($urandom_range(0, 1));
                char_queue.push_back(c);
            end
            else if ($urandom_range(0, 30) == 0)
                push_set($urandom_range(NWORDS - 2, NWORDS + 2), 2);
            else
                push_set($urandom_range(1, 6), 5);
        end
        // close any open set so no word lingers
        c = '{8'd64, 1'b1, 1'b1};
        char_queue.push_back(c);
        // last part of the run without idling
        for (int i = 0; i < 60; i++)
        begin
            c.code = 8'($urandom_range(FCODE, FCODE + 3));
            c.wend = 1'($urandom_range(0, 1));
            c.send = (i % 20 == 19);
            char_queue.push_back(c);
        end

        wait (char_queue.size() <= 60);
        calm = 1;
        wait (char_queue.size() == 0);
        wait (verdict_queue.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("** word_multiset_dominance_flags_top: PASSED **");
        else
            $display("** word_multiset_dominance_flags_top: FAILED **");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("** word_multiset_dominance_flags_top: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
src/wmdf_pkg.sv
src/wmdf_front.sv
src/wmdf_back.sv
src/word_multiset_dominance_flags_top.sv
test/word_multiset_dominance_flags_top_tb.sv
